/* rtl/wir_pkg.sv */
package wir_pkg;

  // Default storage sizes.
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_TAPS   = 16;

  // Fixed widths that follow from the field widths.
  localparam int SCALE_MAX = 16;
  localparam int DIM_W     = 13;
  localparam int ACC_W     = 72;
  localparam int NUM_W     = 71;
  localparam int DEN_W     = 40;
  localparam int WSUM_W    = 39;
  localparam int QUOT_W    = 33;
  localparam int CFG_AW    = 5;

  // Request codes carried in func.
  localparam logic [1:0] FN_WR_PIX  = 2'd0;
  localparam logic [1:0] FN_WR_TAP  = 2'd1;
  localparam logic [1:0] FN_COMPUTE = 2'd2;
  localparam logic [1:0] FN_UNUSED  = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OUT_RANGE = 2'd1;
  localparam logic [1:0] ST_WR_RANGE  = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_ENLARGE = 3'd0;
  localparam logic [2:0] REG_SCALE   = 3'd1;
  localparam logic [2:0] REG_TAPS    = 3'd2;
  localparam logic [2:0] REG_WIDTH   = 3'd3;
  localparam logic [2:0] REG_HEIGHT  = 3'd4;

  typedef struct packed {
    logic       enlarge_mode;
    logic [4:0] scale_factor;
    logic [3:0] window_taps;
    logic [8:0] source_width;
    logic [8:0] source_height;
  } wir_cfg_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } wir_div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } wir_div_rsp_t;

endpackage

/* rtl/wir_if.sv */
interface wir_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [11:0]        column;
  logic [11:0]        line;
  logic signed [31:0] sample;
  logic               sample_missing;
  logic [3:0]         tap_index;
  logic [15:0]        tap_weight;

  modport source (output valid, func, column, line, sample, sample_missing, tap_index,
                  tap_weight, input ready);
  modport sink (input valid, func, column, line, sample, sample_missing, tap_index,
                tap_weight, output ready);
endinterface

interface wir_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               value_missing;
  logic [1:0]         status;

  modport source (output valid, value, value_missing, status, input ready);
  modport sink (input valid, value, value_missing, status, output ready);
endinterface

/* rtl/wir_regs.sv */
module wir_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wir_pkg::CFG_AW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output wir_pkg::wir_cfg_t             cfg
);
  import wir_pkg::*;

  wir_cfg_t   cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes in the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enlarge_mode  <= 1'b0;
      cfg_r.scale_factor  <= 5'd2;
      cfg_r.window_taps   <= 4'd2;
      cfg_r.source_width  <= 9'd256;
      cfg_r.source_height <= 9'd256;
    end else if (wr_en) begin
      case (idx)
        REG_ENLARGE: cfg_r.enlarge_mode  <= pwdata[0];
        REG_SCALE:   cfg_r.scale_factor  <= pwdata[4:0];
        REG_TAPS:    cfg_r.window_taps   <= pwdata[3:0];
        REG_WIDTH:   cfg_r.source_width  <= pwdata[8:0];
        REG_HEIGHT:  cfg_r.source_height <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      REG_ENLARGE: prdata = 32'(cfg_r.enlarge_mode);
      REG_SCALE:   prdata = 32'(cfg_r.scale_factor);
      REG_TAPS:    prdata = 32'(cfg_r.window_taps);
      REG_WIDTH:   prdata = 32'(cfg_r.source_width);
      REG_HEIGHT:  prdata = 32'(cfg_r.source_height);
      default:     prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/wir_div.sv */
module wir_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wir_pkg::wir_div_req_t req,
  output wir_pkg::wir_div_rsp_t rsp
);
  import wir_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r;
  logic [QUOT_W-1:0] quot_r;
  logic [DEN_W:0]    rem_sh;
  logic              fits;

  // One restoring step per cycle, numerator bits taken from the top.
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        quot_r <= '0;
      end else if (busy_r) begin
        num_r  <= {num_r[NUM_W-2:0], 1'b0};
        rem_r  <= fits ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
        quot_r <= {quot_r[QUOT_W-2:0], fits};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/wir_core.sv */
module wir_core #(
  parameter int MAX_WIDTH  = wir_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = wir_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_TAPS   = wir_pkg::DEF_MAX_TAPS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wir_pkg::wir_cfg_t     cfg,
  wir_in_if.sink                in_ch,
  wir_out_if.source             out_ch,
  output wir_pkg::wir_div_req_t div_req,
  input  wir_pkg::wir_div_rsp_t div_rsp
);
  import wir_pkg::*;

  localparam int FS_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int FS_AW    = FS_DEPTH > 1 ? $clog2(FS_DEPTH) : 1;
  localparam int TAW      = MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_DIV, S_EDIV, S_EREAD, S_EWAIT, S_OUT
  } state_t;

  state_t state_r;

  // Frame store and tap table.
  logic [32:0] fs_mem [FS_DEPTH];
  logic [15:0] wt_mem [MAX_TAPS];
  logic [32:0] fs_q;
  logic [15:0] wi_q, wj_q;

  // Result word register.
  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic               out_miss_r;
  logic [1:0]         out_status_r;
  logic signed [31:0] res_value_r;
  logic               res_miss_r;

  // Window scan.
  logic signed [18:0] x0_r, y0_r;
  logic [4:0]         t_r, i_r, j_r;
  logic [1:0]         drain_r;

  // Multiply-accumulate pipeline.
  logic               p1_v_r, ok2_r, ok3_r;
  logic [31:0]        w2_r, w3_r;
  logic signed [31:0] v2_r;
  logic signed [64:0] prod3_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [WSUM_W-1:0]  wsum_r;
  logic [8:0]         count_r;
  logic               neg_r;

  // Replication division lanes.
  logic [11:0] edc_r, edr_r;
  logic [4:0]  erc_r, err_r;
  logic [3:0]  ecnt_r;

  // Combinational terms.
  logic [4:0]         scale;
  logic [DIM_W-1:0]   sw, sh;
  logic               in_acc, out_free;
  logic               pix_oob, tap_oob, enl_oob, shr_oob;
  logic [4:0]         t0, teff;
  logic [16:0]        col_s, row_s;
  logic signed [18:0] x0, y0, x, y;
  logic [17:0]        shr_lim, need_c, need_r, enl_w, enl_h;
  logic               inb, scan_last;
  logic [FS_AW-1:0]   scan_addr, e_addr, rd_addr, wr_addr;
  logic               fs_we, wt_we;
  logic [ACC_W-1:0]   mag;
  logic               acc_empty;
  logic [5:0]         rc_sh, rr_sh;
  logic               gec, ger;
  logic [QUOT_W-1:0]  q;
  logic signed [31:0] div_value;

  // Register values saturated to their legal ranges.
  always_comb begin
    if (cfg.scale_factor == 5'd0) scale = 5'd1;
    else if (cfg.scale_factor > 5'(SCALE_MAX)) scale = 5'(SCALE_MAX);
    else scale = cfg.scale_factor;
    if (cfg.source_width == 9'd0) sw = DIM_W'(1);
    else if (32'(cfg.source_width) > MAX_WIDTH) sw = DIM_W'(MAX_WIDTH);
    else sw = DIM_W'(cfg.source_width);
    if (cfg.source_height == 9'd0) sh = DIM_W'(1);
    else if (32'(cfg.source_height) > MAX_HEIGHT) sh = DIM_W'(MAX_HEIGHT);
    else sh = DIM_W'(cfg.source_height);
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_acc = in_ch.valid && in_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.value         = out_value_r;
  assign out_ch.value_missing = out_miss_r;
  assign out_ch.status        = out_status_r;

  // Range checks and window origin for the word being accepted.
  always_comb begin
    pix_oob = (DIM_W'(in_ch.column) >= sw) || (DIM_W'(in_ch.line) >= sh);
    tap_oob = 32'(in_ch.tap_index) >= MAX_TAPS;
    enl_w   = 18'(sw) * 18'(scale);
    enl_h   = 18'(sh) * 18'(scale);
    enl_oob = (18'(in_ch.column) >= enl_w) || (18'(in_ch.line) >= enl_h);
    shr_lim = 18'(sw) + 18'(scale >> 1);
    need_c  = (18'(in_ch.column) + 18'd1) * 18'(scale);
    need_r  = (18'(in_ch.line) + 18'd1) * 18'(scale);
    shr_oob = (need_c > shr_lim) || (need_r > 18'(sh) + 18'(scale >> 1));
    t0 = {1'b0, cfg.window_taps} + ((cfg.window_taps[0] != scale[0]) ? 5'd1 : 5'd0);
    teff = (32'(t0) > MAX_TAPS) ? 5'(MAX_TAPS) : t0;
    col_s = 17'(in_ch.column) * 17'(scale);
    row_s = 17'(in_ch.line) * 17'(scale);
    x0 = $signed({2'b00, col_s}) + $signed(19'(scale >> 1)) - $signed(19'(teff >> 1));
    y0 = $signed({2'b00, row_s}) + $signed(19'(scale >> 1)) - $signed(19'(teff >> 1));
  end

  // Current tap position of the scan.
  always_comb begin
    x = x0_r + $signed({14'd0, i_r});
    y = y0_r + $signed({14'd0, j_r});
    inb = !x[18] && !y[18] && (x[17:0] < 18'(sw)) && (y[17:0] < 18'(sh));
    scan_addr = FS_AW'(32'(y[17:0]) * MAX_WIDTH + 32'(x[17:0]));
    scan_last = (i_r == t_r - 5'd1) && (j_r == t_r - 5'd1);
    e_addr  = FS_AW'(32'(edr_r) * MAX_WIDTH + 32'(edc_r));
    rd_addr = (state_r == S_EREAD) ? e_addr : scan_addr;
    wr_addr = FS_AW'(32'(in_ch.line) * MAX_WIDTH + 32'(in_ch.column));
    fs_we = in_acc && (in_ch.func == FN_WR_PIX) && !pix_oob;
    wt_we = in_acc && (in_ch.func == FN_WR_TAP) && !tap_oob;
  end

  // Quotient by scale, one bit per cycle on both axes.
  always_comb begin
    rc_sh = {erc_r, edc_r[11]};
    rr_sh = {err_r, edr_r[11]};
    gec = rc_sh >= {1'b0, scale};
    ger = rr_sh >= {1'b0, scale};
  end

  // Divider request and result rounding back to a sample.
  always_comb begin
    mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    acc_empty = (count_r == 9'd0) || (wsum_r == '0);
    div_req.start = (state_r == S_DRAIN) && (drain_r == 2'd3) && !acc_empty;
    div_req.num = {mag[NUM_W-2:0], 1'b0} + NUM_W'(wsum_r);
    div_req.den = {wsum_r, 1'b0};
    q = div_rsp.quot;
    if (!neg_r) begin
      div_value = (q > QUOT_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    end else begin
      div_value = (q > QUOT_W'(32'h8000_0000)) ? 32'sh8000_0000 : $signed(-q[31:0]);
    end
  end

  // Memories: one write port each, registered reads.
  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[wr_addr] <= {in_ch.sample_missing, in_ch.sample};
    fs_q <= fs_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wt_we) wt_mem[TAW'(in_ch.tap_index)] <= in_ch.tap_weight;
    wi_q <= wt_mem[TAW'(i_r)];
    wj_q <= wt_mem[TAW'(j_r)];
  end

  // Weight product, weighted sample, then accumulation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      ok2_r  <= 1'b0;
      ok3_r  <= 1'b0;
    end else begin
      p1_v_r <= (state_r == S_SCAN) && inb;
      ok2_r  <= p1_v_r && !fs_q[32];
      ok3_r  <= ok2_r;
    end
    w2_r    <= 32'(wi_q) * 32'(wj_q);
    v2_r    <= $signed(fs_q[31:0]);
    prod3_r <= $signed({1'b0, w2_r}) * v2_r;
    w3_r    <= w2_r;
    if (in_acc && in_ch.func == FN_COMPUTE) begin
      acc_r   <= '0;
      wsum_r  <= '0;
      count_r <= '0;
    end else if (ok3_r) begin
      acc_r   <= acc_r + ACC_W'(prod3_r);
      wsum_r  <= wsum_r + WSUM_W'(w3_r);
      count_r <= count_r + 9'd1;
    end
  end

  // Sequencer and result word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            out_value_r  <= '0;
            out_miss_r   <= 1'b0;
            out_status_r <= ST_OK;
            case (in_ch.func)
              FN_WR_PIX: begin
                out_valid_r <= 1'b1;
                if (pix_oob) out_status_r <= ST_WR_RANGE;
              end
              FN_WR_TAP: begin
                out_valid_r <= 1'b1;
                if (tap_oob) out_status_r <= ST_WR_RANGE;
              end
              FN_COMPUTE: begin
                if (cfg.enlarge_mode) begin
                  if (enl_oob) begin
                    out_valid_r  <= 1'b1;
                    out_status_r <= ST_OUT_RANGE;
                  end else begin
                    edc_r   <= in_ch.column;
                    edr_r   <= in_ch.line;
                    erc_r   <= '0;
                    err_r   <= '0;
                    ecnt_r  <= '0;
                    state_r <= S_EDIV;
                  end
                end else if (shr_oob) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_OUT_RANGE;
                end else if (teff == 5'd0) begin
                  // An empty window has no contributing pixel.
                  res_value_r <= '0;
                  res_miss_r  <= 1'b1;
                  state_r     <= S_OUT;
                end else begin
                  x0_r    <= x0;
                  y0_r    <= y0;
                  t_r     <= teff;
                  i_r     <= '0;
                  j_r     <= '0;
                  state_r <= S_SCAN;
                end
              end
              default: out_valid_r <= 1'b1;
            endcase
          end
        end
        S_SCAN: begin
          if (i_r == t_r - 5'd1) begin
            i_r <= '0;
            j_r <= j_r + 5'd1;
          end else begin
            i_r <= i_r + 5'd1;
          end
          if (scan_last) begin
            j_r     <= '0;
            drain_r <= '0;
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drain_r <= drain_r + 2'd1;
          if (drain_r == 2'd3) begin
            neg_r <= acc_r[ACC_W-1];
            if (acc_empty) begin
              res_value_r <= '0;
              res_miss_r  <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res_value_r <= div_value;
            res_miss_r  <= 1'b0;
            state_r     <= S_OUT;
          end
        end
        S_EDIV: begin
          edc_r  <= {edc_r[10:0], gec};
          edr_r  <= {edr_r[10:0], ger};
          erc_r  <= gec ? 5'(rc_sh - {1'b0, scale}) : rc_sh[4:0];
          err_r  <= ger ? 5'(rr_sh - {1'b0, scale}) : rr_sh[4:0];
          ecnt_r <= ecnt_r + 4'd1;
          if (ecnt_r == 4'd11) state_r <= S_EREAD;
        end
        S_EREAD: state_r <= S_EWAIT;
        S_EWAIT: begin
          res_miss_r  <= fs_q[32];
          res_value_r <= fs_q[32] ? 32'sd0 : $signed(fs_q[31:0]);
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_value_r  <= res_value_r;
            out_miss_r   <= res_miss_r;
            out_status_r <= ST_OK;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Store writes come only from an accepted word, never during a window read.
  a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fs_we |-> state_r == S_IDLE) else $error("frame store written while busy");
  // A division request always moves the sequencer into the wait state.
  a_div_go: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> state_r == S_DIV) else $error("division request lost");
  // The scan stays inside the window.
  a_scan_rng: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> (i_r < t_r && j_r < t_r)) else $error("scan out of window");
  // No more than 256 contributions reach the accumulator.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    ok3_r |-> count_r < 9'd256) else $error("too many contributions");
`endif

endmodule

/* rtl/weighted_image_rebin.sv */
// A write word returns its result in the cycle after it is accepted.
// Shrink compute: one frame-store read per tap of the effective window, a
// 4-stage multiply-accumulate, then a serial divider.
// Enlarge compute: a 12-step quotient by the scale, then one store read.
// One word is in work at a time. Reset clears control and restores register
// defaults; the frame store and tap table hold no reset and need no clearing pass.
module weighted_image_rebin #(
  parameter int MAX_WIDTH  = wir_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = wir_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_TAPS   = wir_pkg::DEF_MAX_TAPS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  wir_in_if.sink                     in_ch,
  wir_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [wir_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import wir_pkg::*;

  wir_cfg_t     cfg;
  wir_div_req_t div_req;
  wir_div_rsp_t div_rsp;

  // Configuration registers.
  wir_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Store, scan and accumulate.
  wir_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_TAPS   (MAX_TAPS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  // Rounded weighted-mean divider.
  wir_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule
